// ----- hdl/lpsd_pkg.sv -----
// lpsd_pkg: shared constants and codes for the length-prefixed stream deframer
// no dependencies; used by length_prefixed_stream_deframer_unit
`timescale 1ns / 1ps

package lpsd_pkg;

  localparam int BUFFER_BYTES = 4096;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 16;
  localparam int ADDR_W = 3;
  localparam int APB_W  = 32;

  // sum of a 16-bit length and a header size, and the limit, in one width
  localparam int SUM_W = 18;
  localparam logic [SUM_W-1:0] BUF_LIMIT = SUM_W'(BUFFER_BYTES);

  localparam logic [BYTE_W-1:0] HDR_MAX_SHORT = 8'hfd;
  localparam logic [BYTE_W-1:0] HDR_LONG      = 8'hfe;
  localparam logic [1:0]        HDR_SIZE_SHORT = 2'd1;
  localparam logic [1:0]        HDR_SIZE_LONG  = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_REOPEN = 2'd2,
    OP_DROP   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE    = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_ERROR   = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_DROP    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_t;

  // word index of the idle timeout register
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

endpackage

// ----- hdl/length_prefixed_stream_deframer_unit.sv -----
// length_prefixed_stream_deframer_unit: splits a byte stream into length-prefixed frames
// a result is registered into the output buffer when its input beat is accepted
// throughput: one input beat per cycle; a two-entry output buffer keeps s_tready high
//   while one result waits, so input stalls only when both entries are full
// reset: synchronous rst closes the link, clears counters and the timeout register
// depends on lpsd_pkg
`timescale 1ns / 1ps

module length_prefixed_stream_deframer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lpsd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
  input  logic [lpsd_pkg::OP_W-1:0]     s_tuser,   // [1:0] op
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lpsd_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] data
  output logic [lpsd_pkg::KIND_W-1:0]   m_tuser,   // [2:0] kind
  output logic                          m_tlast,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpsd_pkg::APB_W-1:0]    pwdata,
  output logic [lpsd_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    PH_CLOSED  = 3'd0,
    PH_HEADER  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t                        phase, phase_next;
  logic [lpsd_pkg::LEN_W-1:0]    bytes_left, bytes_left_next;
  logic [lpsd_pkg::BYTE_W-1:0]   length_high, length_high_next;
  logic [lpsd_pkg::CNT_W-1:0]    idle_count, idle_count_next;
  logic [lpsd_pkg::CNT_W-1:0]    idle_timeout;

  logic                          out_valid, skid_valid;
  lpsd_pkg::result_t             out_res, skid_res, res;
  logic                          res_valid;

  logic                          accept, take, cfg_wr;
  lpsd_pkg::op_t                 op;
  logic [lpsd_pkg::BYTE_W-1:0]   rx;
  logic [lpsd_pkg::LEN_W-1:0]    len;
  logic [1:0]                    hdr_size;
  logic                          start;
  logic [lpsd_pkg::SUM_W-1:0]    frame_size;
  logic [lpsd_pkg::CNT_W-1:0]    tick_count;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == lpsd_pkg::REG_IDLE_TIMEOUT);
  assign prdata   = (paddr[2] == lpsd_pkg::REG_IDLE_TIMEOUT)
                    ? lpsd_pkg::APB_W'(idle_timeout) : '0;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;
  assign op       = lpsd_pkg::op_t'(s_tuser);
  assign rx       = s_tdata;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.data;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

  assign tick_count = (idle_count == {lpsd_pkg::CNT_W{1'b1}}) ? idle_count
                                                              : idle_count + 1'b1;
  assign frame_size = lpsd_pkg::SUM_W'(len) + lpsd_pkg::SUM_W'(hdr_size);

  // per-beat frame logic
  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    length_high_next = length_high;
    idle_count_next  = idle_count;
    res_valid        = 1'b0;
    res.kind         = lpsd_pkg::KIND_BYTE;
    res.data         = '0;
    res.last         = 1'b0;
    start            = 1'b0;
    len              = {length_high, rx};
    hdr_size         = lpsd_pkg::HDR_SIZE_LONG;

    if (phase == PH_CLOSED) begin
      if (op == lpsd_pkg::OP_REOPEN) begin
        phase_next       = PH_HEADER;
        bytes_left_next  = '0;
        length_high_next = '0;
        idle_count_next  = '0;
      end
    end else begin
      case (op)
        lpsd_pkg::OP_BYTE: begin
          idle_count_next = '0;
          case (phase)
            PH_HEADER: begin
              if (rx <= lpsd_pkg::HDR_MAX_SHORT) begin
                start    = 1'b1;
                len      = lpsd_pkg::LEN_W'(rx);
                hdr_size = lpsd_pkg::HDR_SIZE_SHORT;
              end else if (rx == lpsd_pkg::HDR_LONG) begin
                phase_next = PH_LEN_HI;
              end else begin
                res_valid = 1'b1;
                res.kind  = lpsd_pkg::KIND_ERROR;
              end
            end
            PH_LEN_HI: begin
              length_high_next = rx;
              phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              start = 1'b1;
            end
            PH_PAYLOAD: begin
              res_valid = 1'b1;
              res.kind  = lpsd_pkg::KIND_BYTE;
              res.data  = rx;
              if (bytes_left <= lpsd_pkg::LEN_W'(1)) begin
                res.last        = 1'b1;
                bytes_left_next = '0;
                phase_next      = PH_HEADER;
              end else begin
                bytes_left_next = bytes_left - 1'b1;
              end
            end
            default: begin
              res_valid = 1'b1;
              res.kind  = lpsd_pkg::KIND_ERROR;
            end
          endcase
          if (start) begin
            if (frame_size > lpsd_pkg::BUF_LIMIT) begin
              res_valid = 1'b1;
              res.kind  = lpsd_pkg::KIND_ERROR;
            end else if (len == '0) begin
              res_valid  = 1'b1;
              res.kind   = lpsd_pkg::KIND_EMPTY;
              res.last   = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              bytes_left_next = len;
              phase_next      = PH_PAYLOAD;
            end
          end
        end
        lpsd_pkg::OP_TICK: begin
          idle_count_next = tick_count;
          if (idle_timeout != '0 && tick_count >= idle_timeout) begin
            res_valid = 1'b1;
            res.kind  = lpsd_pkg::KIND_TIMEOUT;
          end
        end
        lpsd_pkg::OP_REOPEN: begin
        end
        lpsd_pkg::OP_DROP: begin
          res_valid = 1'b1;
          res.kind  = lpsd_pkg::KIND_DROP;
        end
        default: begin
        end
      endcase

      // every non-data result closes the link
      if (res_valid && res.kind != lpsd_pkg::KIND_BYTE && res.kind != lpsd_pkg::KIND_EMPTY) begin
        phase_next       = PH_CLOSED;
        bytes_left_next  = '0;
        length_high_next = '0;
        idle_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CLOSED;
      bytes_left   <= '0;
      length_high  <= '0;
      idle_count   <= '0;
      idle_timeout <= '0;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        idle_timeout <= pwdata[lpsd_pkg::CNT_W-1:0];
      end
      if (accept) begin
        phase       <= phase_next;
        bytes_left  <= bytes_left_next;
        length_high <= length_high_next;
        idle_count  <= idle_count_next;
      end
      // output buffer: main register plus skid entry
      if (take) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else if (!(accept && res_valid)) begin
          out_valid <= 1'b0;
        end
      end
      if (accept && res_valid) begin
        if (!out_valid || take) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

endmodule
